FILE: rtl/mfrag_pkg.sv
// ----------------------------------------------------------------------------
// Message fragmenter package
// Shared types and constants for the message fragmenter block.
// ----------------------------------------------------------------------------
package mfrag_pkg;

    // Register reset value of the largest fragment payload size.
    localparam logic [15:0] MAX_FRAG_RESET = 16'd1024;

    // Bit positions inside the result tuser group.
    localparam int TUSER_START  = 0;
    localparam int TUSER_END    = 1;
    localparam int TUSER_PVALID = 2;

    // One incoming message word.
    typedef struct packed {
        logic [7:0]  data_byte;
        logic [30:0] total_length;
        logic [15:0] channel_id;
        logic [7:0]  priority_req;
        logic        use_given_id;
        logic [31:0] given_id;
    } item_t;

    // One outgoing envelope word.
    typedef struct packed {
        logic [15:0] out_channel;
        logic [7:0]  out_priority;
        logic [31:0] out_message_id;
        logic [30:0] out_total_length;
        logic [15:0] fragment_sequence;
        logic        start_flag;
        logic        end_flag;
        logic        payload_valid;
        logic [7:0]  payload_out;
        logic        fragment_last;
    } result_t;

endpackage

FILE: rtl/mfrag_core.sv
// ----------------------------------------------------------------------------
// Message fragmenter core
// Holds the message header and fragment counters and forms the envelope
// for the word currently offered.
// ----------------------------------------------------------------------------
module mfrag_core
    import mfrag_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  item_t       item,
    input  logic [15:0] max_fragment_bytes,
    output result_t     result
);

    logic        in_msg_reg;
    logic [30:0] bytes_done_reg;
    logic [15:0] fill_reg;
    logic [15:0] seq_reg;
    logic [31:0] id_counter_reg;
    logic [15:0] held_channel_reg;
    logic [7:0]  held_priority_reg;
    logic [31:0] held_id_reg;
    logic [30:0] held_total_reg;

    logic        first;
    logic        empty;
    logic [30:0] eff_total;
    logic [30:0] eff_done;
    logic [15:0] eff_fill;
    logic [15:0] eff_seq;
    logic [31:0] drawn_id;
    logic [31:0] eff_id;
    logic [15:0] chunk;
    logic [30:0] frag_start;
    logic [31:0] done_inc;
    logic [16:0] fill_inc;
    logic        is_first;
    logic        is_end;
    logic        frag_last;
    logic        msg_done;

    // Values seen by this word: a new message starts from cleared counters.
    always_comb
    begin
        first     = !in_msg_reg;
        eff_total = first ? item.total_length : held_total_reg;
        eff_done  = first ? '0 : bytes_done_reg;
        eff_fill  = first ? '0 : fill_reg;
        eff_seq   = first ? '0 : seq_reg;
        empty     = first && (item.total_length == '0);
    end

    // Id counter steps before use and skips zero on wrap.
    always_comb
    begin
        drawn_id = id_counter_reg + 32'd1;
        if (drawn_id == '0)
        begin
            drawn_id = 32'd1;
        end
        if (!first)
        begin
            eff_id = held_id_reg;
        end
        else if (item.use_given_id)
        begin
            eff_id = item.given_id;
        end
        else
        begin
            eff_id = drawn_id;
        end
    end

    // Fragment position and boundary decisions; a size of zero acts as one.
    always_comb
    begin
        chunk      = (max_fragment_bytes == '0) ? 16'd1 : max_fragment_bytes;
        frag_start = eff_done - {15'd0, eff_fill};
        is_first   = (frag_start == '0);
        is_end     = ({1'b0, frag_start} + {16'd0, chunk}) >= {1'b0, eff_total};
        done_inc   = {1'b0, eff_done} + 32'd1;
        fill_inc   = {1'b0, eff_fill} + 17'd1;
        msg_done   = done_inc >= {1'b0, eff_total};
        frag_last  = (fill_inc >= {1'b0, chunk}) || msg_done;
    end

    // Envelope for the offered word.
    always_comb
    begin
        result.out_channel    = first ? item.channel_id : held_channel_reg;
        result.out_priority   = first ? item.priority_req : held_priority_reg;
        result.out_message_id = eff_id;
        if (empty)
        begin
            result.out_total_length  = '0;
            result.fragment_sequence = '0;
            result.start_flag        = 1'b1;
            result.end_flag          = 1'b1;
            result.payload_valid     = 1'b0;
            result.payload_out       = '0;
            result.fragment_last     = 1'b1;
        end
        else
        begin
            result.out_total_length  = eff_total;
            result.fragment_sequence = eff_seq;
            result.start_flag        = is_first;
            result.end_flag          = is_end;
            result.payload_valid     = 1'b1;
            result.payload_out       = item.data_byte;
            result.fragment_last     = frag_last;
        end
    end

    // Message and fragment counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_msg_reg     <= 1'b0;
            bytes_done_reg <= '0;
            fill_reg       <= '0;
            seq_reg        <= '0;
            id_counter_reg <= 32'd1;
        end
        else if (accept)
        begin
            if (first && !item.use_given_id)
            begin
                id_counter_reg <= drawn_id;
            end
            if (empty)
            begin
                in_msg_reg     <= 1'b0;
                bytes_done_reg <= '0;
                fill_reg       <= '0;
                seq_reg        <= '0;
            end
            else
            begin
                in_msg_reg     <= !msg_done;
                bytes_done_reg <= done_inc[30:0];
                fill_reg       <= frag_last ? 16'd0 : fill_inc[15:0];
                seq_reg        <= eff_seq + {15'd0, frag_last};
            end
        end
    end

    // Header latched on the first word of a message.
    always_ff @(posedge clk)
    begin
        if (accept && first)
        begin
            held_channel_reg  <= item.channel_id;
            held_priority_reg <= item.priority_req;
            held_id_reg       <= eff_id;
            held_total_reg    <= item.total_length;
        end
    end

endmodule

FILE: rtl/message_fragmenter_top.sv
// A result word is registered and appears on the output in the cycle after its input word is accepted.
// Throughput: one word per cycle while the output is not stalled; the output register lets a new word in while the
// previous result is taken in the same cycle.
// Each input word gives exactly one result word, an empty message included.
// Reset (rst_n low, asynchronous) clears the output valid flag and the message counters,
// sets the id counter to 1 and the fragment size to 1024.
// ----------------------------------------------------------------------------
// Message fragmenter top level
// Splits a byte stream of messages into fragment envelopes, one word per byte or one for an empty message.
// ----------------------------------------------------------------------------
module message_fragmenter_top
    import mfrag_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    // Fragment size register write.
    input  logic         cfg_wr_en,
    input  logic [15:0]  cfg_wr_data,
    // Input stream.
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata, low bit up: data_byte[7:0], total_length[38:8], channel_id[54:39],
    // priority_req[62:55], given_id[94:63], zero[95].
    input  logic [95:0]  s_tdata,
    // tuser: use_given_id[0].
    input  logic [0:0]   s_tuser,
    // Output stream.
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata, low bit up: out_channel[15:0], out_priority[23:16],
    // out_message_id[55:24], out_total_length[86:56], fragment_sequence[102:87],
    // payload_out[110:103], zero[111].
    output logic [111:0] m_tdata,
    // tuser, low bit up: start_flag[0], end_flag[1], payload_valid[2].
    output logic [2:0]   m_tuser,
    // tlast: fragment_last.
    output logic         m_tlast
);

    logic [15:0] max_frag_reg;
    logic        out_valid_reg;
    result_t     result_reg;
    result_t     result_next;
    item_t       item;
    logic        accept;

    // Fragment size register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_frag_reg <= MAX_FRAG_RESET;
        end
        else if (cfg_wr_en)
        begin
            max_frag_reg <= cfg_wr_data;
        end
    end

    // Unpack the input word.
    always_comb
    begin
        item.data_byte    = s_tdata[7:0];
        item.total_length = s_tdata[38:8];
        item.channel_id   = s_tdata[54:39];
        item.priority_req = s_tdata[62:55];
        item.given_id     = s_tdata[94:63];
        item.use_given_id = s_tuser[0];
    end

    // Accept whenever the output register is free or drains this cycle.
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    mfrag_core u_core (
        .clk                (clk),
        .rst_n              (rst_n),
        .accept             (accept),
        .item               (item),
        .max_fragment_bytes (max_frag_reg),
        .result             (result_next)
    );

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    // Pack the result word.
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0,
                       result_reg.payload_out,
                       result_reg.fragment_sequence,
                       result_reg.out_total_length,
                       result_reg.out_message_id,
                       result_reg.out_priority,
                       result_reg.out_channel};
    assign m_tuser[TUSER_START]  = result_reg.start_flag;
    assign m_tuser[TUSER_END]    = result_reg.end_flag;
    assign m_tuser[TUSER_PVALID] = result_reg.payload_valid;
    assign m_tlast  = result_reg.fragment_last;

endmodule

FILE: rtl/mfrag_checker.sv
// ----------------------------------------------------------------------------
// Message fragmenter checker
// Port-level assertions on the fragmenter, bound to the top level.
// ----------------------------------------------------------------------------
module mfrag_checker
    import mfrag_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [111:0] m_tdata,
    input logic [2:0]   m_tuser,
    input logic         m_tlast
);

    // A stalled result word holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
    else $error("stalled result word changed");

    // Every accepted input word shows up as a result word on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
    else $error("accepted word gave no result");

    // An empty envelope is a complete one-fragment message of length zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[TUSER_PVALID] |-> m_tuser[TUSER_START] && m_tuser[TUSER_END]
            && m_tlast && (m_tdata[86:56] == '0) && (m_tdata[110:87] == '0))
    else $error("malformed empty envelope");

    // The first fragment of a message always carries sequence number zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[TUSER_START] |-> (m_tdata[102:87] == '0))
    else $error("start fragment with nonzero sequence");

endmodule

bind message_fragmenter_top mfrag_checker u_mfrag_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

FILE: test/message_fragmenter_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Message fragmenter testbench
// Streams message bytes into the fragmenter under random gaps and stalls on
// both sides and checks every envelope word against a software model of the
// fragmentation rules. The fragment size is changed between phases, also in
// the middle of a message.
// ----------------------------------------------------------------------------
module message_fragmenter_top_test;
    import mfrag_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int LONG_HOLD    = 150;
    localparam int DRAIN_CYCLES = 4;

    // Tracks the fragmenter state and keeps the envelopes still to come.
    class envelope_scoreboard;
        logic [15:0] frag_size;
        bit          in_message;
        logic [30:0] bytes_sent;
        logic [15:0] frag_fill;
        logic [15:0] frag_seq;
        logic [31:0] id_count;
        logic [15:0] hdr_channel;
        logic [7:0]  hdr_priority;
        logic [31:0] hdr_id;
        logic [30:0] hdr_total;
        result_t     envelopes_due[$];
        int          error_count;

        function new();
            frag_size    = MAX_FRAG_RESET;
            in_message   = 1'b0;
            bytes_sent   = '0;
            frag_fill    = '0;
            frag_seq     = '0;
            id_count     = 32'd1;
            hdr_channel  = '0;
            hdr_priority = '0;
            hdr_id       = '0;
            hdr_total    = '0;
            error_count  = 0;
        endfunction

        // Works out the envelope that one accepted byte word gives.
        function void add_byte_word(item_t w);
            logic [63:0] chunk;
            logic [63:0] frag_base;
            bit          frag_end;
            result_t     env;
            chunk = (frag_size == 16'd0) ? 64'd1 : 64'(frag_size);
            // The first word of a message latches the header.
            if (!in_message)
            begin
                hdr_total    = w.total_length;
                hdr_channel  = w.channel_id;
                hdr_priority = w.priority_req;
                if (w.use_given_id)
                    hdr_id = w.given_id;
                else
                begin
                    id_count = id_count + 32'd1;
                    if (id_count == 32'd0)
                        id_count = 32'd1;
                    hdr_id = id_count;
                end
                bytes_sent = '0;
                frag_fill  = '0;
                frag_seq   = '0;
            end
            env.out_channel      = hdr_channel;
            env.out_priority     = hdr_priority;
            env.out_message_id   = hdr_id;
            env.out_total_length = hdr_total;
            // An empty message gives one envelope with both flags and no payload.
            if (!in_message && hdr_total == 31'd0)
            begin
                env.fragment_sequence = '0;
                env.start_flag        = 1'b1;
                env.end_flag          = 1'b1;
                env.payload_valid     = 1'b0;
                env.payload_out       = '0;
                env.fragment_last     = 1'b1;
                envelopes_due.push_back(env);
                return;
            end
            in_message = 1'b1;
            frag_base  = 64'(bytes_sent) - 64'(frag_fill);
            frag_end   = (64'(frag_fill) + 64'd1 >= chunk) ||
                         (64'(bytes_sent) + 64'd1 >= 64'(hdr_total));
            env.fragment_sequence = frag_seq;
            env.start_flag        = (frag_base == 64'd0);
            env.end_flag          = (frag_base + chunk >= 64'(hdr_total));
            env.payload_valid     = 1'b1;
            env.payload_out       = w.data_byte;
            env.fragment_last     = frag_end;
            envelopes_due.push_back(env);
            // Advance the byte and fragment counters.
            bytes_sent = bytes_sent + 31'd1;
            frag_fill  = frag_fill + 16'd1;
            if (frag_end)
            begin
                frag_fill = '0;
                frag_seq  = frag_seq + 16'd1;
            end
            if (bytes_sent >= hdr_total)
                in_message = 1'b0;
        endfunction

        function void compare(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $display("%0t: %s expected %h actual %h", $time, name, want, got);
                error_count++;
            end
        endfunction

        // Checks one envelope word taken from the output against the oldest one due.
        function void check_envelope(result_t got);
            result_t want;
            if (envelopes_due.size() == 0)
            begin
                $display("%0t: envelope expected none actual %h", $time, got);
                error_count++;
                return;
            end
            want = envelopes_due.pop_front();
            compare("out_channel", want.out_channel, got.out_channel);
            compare("out_priority", want.out_priority, got.out_priority);
            compare("out_message_id", want.out_message_id, got.out_message_id);
            compare("out_total_length", want.out_total_length, got.out_total_length);
            compare("fragment_sequence", want.fragment_sequence, got.fragment_sequence);
            compare("start_flag", want.start_flag, got.start_flag);
            compare("end_flag", want.end_flag, got.end_flag);
            compare("payload_valid", want.payload_valid, got.payload_valid);
            compare("payload_out", want.payload_out, got.payload_out);
            compare("fragment_last", want.fragment_last, got.fragment_last);
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         cfg_wr_en;
    logic [15:0]  cfg_wr_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [95:0]  s_tdata;
    logic [0:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [111:0] m_tdata;
    logic [2:0]   m_tuser;
    logic         m_tlast;

    envelope_scoreboard board;
    bit                 tx_calm;
    bit                 rx_calm;
    bit                 hold_request;
    bit                 envelope_taken;
    longint             bytes_left;
    int unsigned        cycle_count;

    message_fragmenter_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    initial
        clk = 1'b0;

    always #10 clk = ~clk;

    // Wait before the next word; runs of zero waits come and go at random.
    function automatic int draw_wait(inout bit calm);
        if ($urandom_range(0, 39) == 0)
            calm = !calm;
        return calm ? 0 : int'($urandom_range(0, 6));
    endfunction

    function automatic item_t random_word();
        item_t w;
        w.data_byte    = 8'($urandom);
        w.total_length = 31'($urandom);
        w.channel_id   = 16'($urandom);
        w.priority_req = 8'($urandom);
        w.use_given_id = 1'($urandom);
        w.given_id     = $urandom;
        return w;
    endfunction

    function automatic item_t header_word(logic [30:0] len, logic [15:0] chan,
                                          logic [7:0] prio, bit use_id,
                                          logic [31:0] id, logic [7:0] data);
        item_t w;
        w.data_byte    = data;
        w.total_length = len;
        w.channel_id   = chan;
        w.priority_req = prio;
        w.use_given_id = use_id;
        w.given_id     = id;
        return w;
    endfunction

    // Mostly short messages, some empty, a few a few hundred bytes long.
    function automatic logic [30:0] pick_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 31'd0;
        else if (r < 70)
            return 31'($urandom_range(1, 12));
        else if (r < 92)
            return 31'($urandom_range(13, 60));
        else
            return 31'($urandom_range(61, 300));
    endfunction

    // Offers one word after a random gap and waits until it is taken.
    task automatic send_word(input item_t w);
        int gap;
        gap = draw_wait(tx_calm);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, w.given_id, w.priority_req, w.channel_id,
                     w.total_length, w.data_byte};
        s_tuser  <= w.use_given_id;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.add_byte_word(w);
        if (bytes_left == 0)
            bytes_left = w.total_length;
        if (bytes_left > 0)
            bytes_left--;
    endtask

    // Random words; a new header is drawn whenever the previous message is complete.
    task automatic send_random(input int count);
        item_t w;
        for (int i = 0; i < count; i++)
        begin
            w = random_word();
            if (bytes_left == 0)
                w.total_length = pick_length();
            send_word(w);
        end
    endtask

    // Stops offering and waits until every envelope due has come out.
    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (board.envelopes_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_frag_size(input logic [15:0] size);
        wait_drained();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= size;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        board.frag_size = size;
    endtask

    // Output side: random stalls after each taken word, and one long hold on request.
    initial
    begin
        int stall;
        m_tready = 1'b0;
        stall    = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall        = LONG_HOLD;
            end
            else if (envelope_taken)
                stall = draw_wait(rx_calm);
            envelope_taken = 1'b0;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                stall--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Unpack and check each envelope word taken from the output.
    always @(posedge clk)
    begin
        result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.out_channel       = m_tdata[15:0];
            got.out_priority      = m_tdata[23:16];
            got.out_message_id    = m_tdata[55:24];
            got.out_total_length  = m_tdata[86:56];
            got.fragment_sequence = m_tdata[102:87];
            got.payload_out       = m_tdata[110:103];
            got.start_flag        = m_tuser[TUSER_START];
            got.end_flag          = m_tuser[TUSER_END];
            got.payload_valid     = m_tuser[TUSER_PVALID];
            got.fragment_last     = m_tlast;
            board.check_envelope(got);
            envelope_taken = 1'b1;
        end
    end

    // Run time limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("message_fragmenter_top: mismatch");
            $finish;
        end
    end

    initial
    begin
        logic [15:0] size;
        item_t       w;
        board       = new();
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        bytes_left  = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Empty messages with a counter id and with all header fields at their maximum.
        send_word(header_word(31'd0, 16'h1234, 8'h10, 1'b0, 32'h0, 8'h55));
        send_word(header_word(31'd0, 16'hFFFF, 8'hFF, 1'b1, 32'hFFFF_FFFF, 8'hFF));
        // One fragment under the reset size; header fields change after the first byte.
        send_word(header_word(31'd3, 16'h0000, 8'h00, 1'b1, 32'h0, 8'h00));
        w = random_word();
        w.data_byte = 8'hFF;
        send_word(w);
        w = random_word();
        w.data_byte = 8'hA5;
        send_word(w);
        // One byte per fragment.
        write_frag_size(16'd1);
        send_word(header_word(31'd3, 16'h00F0, 8'h0F, 1'b0, 32'h0, 8'h3C));
        send_random(2);
        // A size of zero behaves as one.
        write_frag_size(16'd0);
        send_word(header_word(31'd2, 16'h8001, 8'h80, 1'b1, 32'h8000_0001, 8'hC3));
        send_random(1);
        // Size changed in the middle of a message.
        write_frag_size(16'd2);
        send_word(header_word(31'd5, 16'h0101, 8'h01, 1'b0, 32'h0, 8'h11));
        send_random(2);
        write_frag_size(16'd1);
        send_random(2);

        // Random phases over a range of fragment sizes, the extremes included.
        for (int phase = 0; phase < 14; phase++)
        begin
            case (phase % 7)
                0: size = 16'hFFFF;
                1: size = 16'($urandom_range(1, 8));
                2: size = 16'd0;
                3: size = 16'($urandom_range(1, 64));
                4: size = 16'($urandom);
                5: size = 16'd3;
                default: size = 16'd1;
            endcase
            write_frag_size(size);
            if (phase == 3 || phase == 10)
                hold_request = 1'b1;
            send_random(40);
        end

        // A message of the largest length, left unfinished at the end of the run.
        write_frag_size(16'($urandom_range(1, 16)));
        send_word(header_word(31'h7FFF_FFFF, 16'($urandom), 8'($urandom), 1'b0,
                              32'h0, 8'($urandom)));
        send_random(24);

        wait_drained();
        if (board.error_count == 0 && board.envelopes_due.size() == 0)
            $display("message_fragmenter_top: match");
        else
            $display("message_fragmenter_top: mismatch");
        $finish;
    end

endmodule

FILE: message_fragmenter_top.f
rtl/mfrag_pkg.sv
rtl/mfrag_core.sv
rtl/message_fragmenter_top.sv
rtl/mfrag_checker.sv
test/message_fragmenter_top_test.sv
